>>> hdl/mpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the sorted-cell min priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int CAPACITY = 64;                   // keys held, 2 .. 127
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 7;                    // occupancy field width

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_EXTRACT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // broadcast to every cell in the cycle a command is taken
    typedef struct packed {
        logic                    ins;   // sorted insert of key
        logic                    ext;   // shift toward head, drop head
        logic signed [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

>>> hdl/min_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue_unit
// Bounded min priority queue of signed keys built as a sorted chain of cells.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                         tuser
//  --------  ---  ----------------------------  ---------------------
//  s_axis    in   [31:0] key                    [1:0] command
//  m_axis    out  [31:0] min_key, [38:32] occ   [1:0] status
//
//  Every transfer is handled in a single step: the whole chain compares the
//  broadcast key in parallel and each cell loads its new key at the same
//  edge, so a command can be taken every cycle while m_axis does not stall.
//  Result sits in one output register; s_axis is ready while that register
//  is empty or being drained, so a stall on m_axis stalls s_axis directly.
//  Synchronous active-low reset empties the queue and the output register;
//  cell contents are left as they are and are never read while unoccupied.
//
// Cells are kept in ascending order with the minimum in cell 0. An insert
// keeps every cell whose key is <= the new key; the first cell past them takes
// the new key and all later cells take the key of their left neighbor. An
// extract shifts every cell one step toward the head. Occupancy is tracked
// by a count; cell i is occupied when i < count.
// ----------------------------------------------------------------------------
module min_priority_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,    // [31:0] key
    input  logic [1:0]  i_s_axis_tuser,    // [1:0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,    // [31:0] min_key, [38:32] occupancy
    output logic [1:0]  o_m_axis_tuser     // [1:0] status
);

    localparam int KW = mpq_pkg::KEY_W;
    localparam int NC = mpq_pkg::CAPACITY;
    localparam int CW = mpq_pkg::CNT_W;
    localparam int OW = mpq_pkg::OCC_W;

    // ---------------- input decode ----------------
    logic                  w_take;
    mpq_pkg::t_cmd         w_cmd;
    logic signed [KW-1:0]  w_in_key;
    logic                  w_empty;
    logic                  w_full;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;
    logic signed [KW-1:0] r_out_key;
    logic signed [KW-1:0] n_out_key;
    mpq_pkg::t_status     r_out_status;
    mpq_pkg::t_status     n_out_status;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_take   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cmd    = mpq_pkg::t_cmd'(i_s_axis_tuser);
    assign w_in_key = $signed(i_s_axis_tdata);

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CW'(NC));

    // ---------------- cell chain ----------------
    mpq_pkg::t_cell_ctl   w_ctl;
    logic signed [KW-1:0] w_key [NC];
    logic                 w_le  [NC];

    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++) begin : g_cell
            logic                 w_left_le;
            logic signed [KW-1:0] w_left_key;
            logic signed [KW-1:0] w_right_key;

            if (gi == 0) begin : g_head
                assign w_left_le  = 1'b1;
                assign w_left_key = w_ctl.key;
            end else begin : g_body
                assign w_left_le  = w_le[gi-1];
                assign w_left_key = w_key[gi-1];
            end

            if (gi == NC - 1) begin : g_tail
                assign w_right_key = w_key[gi];
            end else begin : g_mid
                assign w_right_key = w_key[gi+1];
            end

            mpq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (r_count > CW'(gi)),
                .i_left_le   (w_left_le),
                .i_left_key  (w_left_key),
                .i_right_key (w_right_key),
                .o_key       (w_key[gi]),
                .o_le        (w_le[gi])
            );
        end
    endgenerate

    // ---------------- command handling ----------------
    always_comb begin
        w_ctl.ins    = 1'b0;
        w_ctl.ext    = 1'b0;
        w_ctl.key    = w_in_key;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_key    = r_out_key;
        n_out_status = r_out_status;
        if (w_take) begin
            n_out_valid  = 1'b1;
            n_out_key    = '0;
            n_out_status = mpq_pkg::ST_OK;
            unique case (w_cmd)
                mpq_pkg::CMD_INSERT: begin
                    if (w_full) begin
                        n_out_status = mpq_pkg::ST_FULL;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + CW'(1);
                    end
                end
                mpq_pkg::CMD_PEEK,
                mpq_pkg::CMD_EXTRACT: begin
                    if (w_empty) begin
                        n_out_key    = -KW'(1);
                        n_out_status = mpq_pkg::ST_EMPTY;
                    end else begin
                        n_out_key = w_key[0];
                        if (w_cmd == mpq_pkg::CMD_EXTRACT) begin
                            w_ctl.ext = 1'b1;
                            n_count   = r_count - CW'(1);
                        end
                    end
                end
                default: begin
                    // unused command: no operation
                end
            endcase
        end
    end

    // ---------------- registers ----------------
    logic [OW-1:0] r_out_occ;
    logic [OW-1:0] n_out_occ;

    generate
        if (CW >= OW) begin : g_occ_trunc
            assign n_out_occ = w_take ? n_count[OW-1:0] : r_out_occ;
        end else begin : g_occ_ext
            assign n_out_occ = w_take ? {{(OW-CW){1'b0}}, n_count} : r_out_occ;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out_key    <= n_out_key;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(40-KW-OW){1'b0}}, r_out_occ, r_out_key};
    assign o_m_axis_tuser  = r_out_status;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NC))
        else $error("queue count above capacity");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_key[0] <= w_key[1]))
        else $error("head cells out of order");

    a_extract_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_cmd == mpq_pkg::CMD_EXTRACT && !w_empty)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("extract did not shrink queue");

    a_peek_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_cmd == mpq_pkg::CMD_PEEK && !w_empty)
        |=> (r_out_key == $past(w_key[0]) && r_out_status == mpq_pkg::ST_OK))
        else $error("peek result differs from head cell");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == mpq_pkg::ST_FULL) |-> w_full)
        else $error("full status while queue not full");

endmodule

>>> hdl/mpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: holds a key, compares it with the broadcast
// key and takes its own, the new or a neighbor's key.
// ----------------------------------------------------------------------------
module mpq_cell (
    input  logic                              i_clk,
    input  mpq_pkg::t_cell_ctl                i_ctl,
    input  logic                              i_occ,        // slot holds a key
    input  logic                              i_left_le,    // left slot stays put
    input  logic signed [mpq_pkg::KEY_W-1:0]  i_left_key,
    input  logic signed [mpq_pkg::KEY_W-1:0]  i_right_key,
    output logic signed [mpq_pkg::KEY_W-1:0]  o_key,
    output logic                              o_le
);

    logic signed [mpq_pkg::KEY_W-1:0] r_key;
    logic signed [mpq_pkg::KEY_W-1:0] n_key;

    // equal keys stay ahead of the new one
    assign o_le  = i_occ && (r_key <= i_ctl.key);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins) begin
            if (!o_le) begin
                n_key = i_left_le ? i_ctl.key : i_left_key;
            end
        end else if (i_ctl.ext) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule
